FILE: rtl/sal_pkg.sv
// Shared constants, types and codes for the shifting array list.
`timescale 1ns / 1ps

package sal_pkg;

  // List geometry
  localparam int DEPTH   = 128;
  localparam int WIDTH   = 32;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 8;
  localparam logic [CNT_W-1:0] DEPTH_CNT = DEPTH[CNT_W-1:0];

  // Read select tree: groups of eight cells, then one of sixteen groups
  localparam int GROUP   = 8;
  localparam int GSEL_W  = 3;
  localparam int NGROUP  = DEPTH / GROUP;
  localparam int NGSEL_W = 4;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_INSERT      = 3'd1,
    OP_READ        = 3'd2,
    OP_REMOVE_LAST = 3'd3,
    OP_ERASE       = 3'd4,
    OP_CLEAR       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             append;
    logic             insert;
    logic             erase;
    logic             rd_ok;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

FILE: rtl/sal_cell.sv
// One storage cell of the list: holds an entry and trades it with its neighbours.
`timescale 1ns / 1ps

module sal_cell (
  input  logic                           clk,
  input  logic [sal_pkg::CNT_W-1:0]      idx,
  input  sal_pkg::cell_cmd_t             cmd,
  input  logic [sal_pkg::WIDTH-1:0]      value,
  input  logic [sal_pkg::WIDTH-1:0]      left,
  input  logic [sal_pkg::WIDTH-1:0]      right,
  output logic [sal_pkg::WIDTH-1:0]      data
);

  logic [sal_pkg::WIDTH-1:0] data_next;

  // Pick load, shift up from the left, shift down from the right, or hold
  always_comb begin
    data_next = data;
    if (cmd.append && (idx == cmd.count)) begin
      data_next = value;
    end else if (cmd.insert) begin
      if (idx == cmd.pos) begin
        data_next = value;
      end else if ((idx > cmd.pos) && (idx <= cmd.count)) begin
        data_next = left;
      end
    end else if (cmd.erase && (idx >= cmd.pos)
                 && ((idx + sal_pkg::CNT_W'(1)) < cmd.count)) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: rtl/sal_ctrl.sv
// Entry count register, bounds checks and the command broadcast to the cells.
`timescale 1ns / 1ps

module sal_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [2:0]                    opcode,
  input  logic [sal_pkg::POS_W-1:0]     position,
  output sal_pkg::cell_cmd_t            cmd,
  output sal_pkg::status_t              status,
  output logic [sal_pkg::CNT_W-1:0]     count
);

  logic [sal_pkg::CNT_W-1:0] count_next;
  logic [sal_pkg::CNT_W-1:0] pos_ext;
  logic                      full;

  assign pos_ext = sal_pkg::CNT_W'(position);
  assign full    = (count >= sal_pkg::DEPTH_CNT);

  // Decode the item and check its bounds against the current count
  always_comb begin
    cmd        = '0;
    cmd.pos    = pos_ext;
    cmd.count  = count;
    status     = sal_pkg::ST_OK;
    count_next = count;
    if (accept) begin
      unique case (sal_pkg::op_t'(opcode))
        sal_pkg::OP_APPEND: begin
          if (full) begin
            status = sal_pkg::ST_FULL;
          end else begin
            cmd.append = 1'b1;
            count_next = count + sal_pkg::CNT_W'(1);
          end
        end
        sal_pkg::OP_INSERT: begin
          if (full) begin
            status = sal_pkg::ST_FULL;
          end else if (pos_ext > count) begin
            status = sal_pkg::ST_RANGE;
          end else begin
            cmd.insert = 1'b1;
            count_next = count + sal_pkg::CNT_W'(1);
          end
        end
        sal_pkg::OP_READ: begin
          if (pos_ext >= count) begin
            status = sal_pkg::ST_RANGE;
          end else begin
            cmd.rd_ok = 1'b1;
          end
        end
        sal_pkg::OP_REMOVE_LAST: begin
          if (count != '0) begin
            count_next = count - sal_pkg::CNT_W'(1);
          end
        end
        sal_pkg::OP_ERASE: begin
          if (pos_ext >= count) begin
            status = sal_pkg::ST_RANGE;
          end else begin
            cmd.erase  = 1'b1;
            count_next = count - sal_pkg::CNT_W'(1);
          end
        end
        sal_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

FILE: rtl/shifting_array_list.sv
// Top level of the shifting array list: cell row, controller and read select.
//
//   channel   direction  handshake                 payload
//   command   in         start && !busy            opcode, position, value
//   result    out        done (one cycle, no hold) status, read_data, entry_count,
//                                                  free_slots, is_empty
//
// In the cycle of acceptance the cell row shifts or loads its entries, while
// a first rank of 8:1 selects captures the read candidates; a 16:1 select
// then fills the result register. done is registered from s1_valid, which is
// set on acceptance, and busy is high while s1_valid is set.
// Reset clears the count and all control state; entry contents are left as
// they are. The receiver cannot stall, so no result is ever held back.
`timescale 1ns / 1ps

module shifting_array_list (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        opcode,
  input  logic [sal_pkg::POS_W-1:0]         position,
  input  logic [sal_pkg::WIDTH-1:0]         value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [sal_pkg::WIDTH-1:0]         read_data,
  output logic [sal_pkg::CNT_W-1:0]         entry_count,
  output logic [sal_pkg::CNT_W-1:0]         free_slots,
  output logic                              is_empty
);

  logic                              accept;
  sal_pkg::cell_cmd_t                cmd;
  sal_pkg::status_t                  st_now;
  logic [sal_pkg::CNT_W-1:0]         count;
  logic [sal_pkg::WIDTH-1:0]         cells [sal_pkg::DEPTH];
  logic [sal_pkg::WIDTH-1:0]         grp [sal_pkg::NGROUP];
  logic                              s1_valid;
  sal_pkg::status_t                  s1_status;
  logic                              s1_rd_ok;
  logic [sal_pkg::NGSEL_W-1:0]       s1_gsel;

  assign accept = start && !busy;
  assign busy   = s1_valid;

  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (opcode),
    .position (position),
    .cmd      (cmd),
    .status   (st_now),
    .count    (count)
  );

  // Row of cells, each linked to both neighbours
  for (genvar i = 0; i < sal_pkg::DEPTH; i++) begin : g_cell
    logic [sal_pkg::WIDTH-1:0] left_d;
    logic [sal_pkg::WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cells[i-1];
    end
    if (i == sal_pkg::DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cells[i+1];
    end
    sal_cell u_cell (
      .clk   (clk),
      .idx   (sal_pkg::CNT_W'(i)),
      .cmd   (cmd),
      .value (value),
      .left  (left_d),
      .right (right_d),
      .data  (cells[i])
    );
  end

  // First select rank: one candidate per group of eight cells
  for (genvar g = 0; g < sal_pkg::NGROUP; g++) begin : g_grp
    always_ff @(posedge clk) begin
      if (accept) begin
        grp[g] <= cells[{sal_pkg::NGSEL_W'(g), position[sal_pkg::GSEL_W-1:0]}];
      end
    end
  end

  // Hold the item's status between the two ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st_now;
      s1_rd_ok  <= cmd.rd_ok;
      s1_gsel   <= position[sal_pkg::POS_W-1:sal_pkg::GSEL_W];
    end
  end

  // Result register: strobe for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      status      <= s1_status;
      read_data   <= s1_rd_ok ? grp[s1_gsel] : '0;
      entry_count <= count;
      free_slots  <= sal_pkg::DEPTH_CNT - count;
      is_empty    <= (count == '0);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sal_pkg::DEPTH_CNT)
    else $error("entry count beyond capacity");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("result did not follow two cycles after an item");

  a_full_slots: assert property (@(posedge clk) disable iff (rst)
    done && (status == sal_pkg::ST_FULL) |-> (free_slots == '0))
    else $error("full status with free slots left");

  a_err_data: assert property (@(posedge clk) disable iff (rst)
    done && (status != sal_pkg::ST_OK) |-> (read_data == '0))
    else $error("read data not zero on a failed item");

endmodule
